FILE: rtl/assert_macros.svh
// Assertion macros used by the deque checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDEQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BDEQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

FILE: rtl/bdeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdeq_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ACTION_W  = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned DEPTH_DEF = 16;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_DRAIN      = 3'd4
    } action_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_POP_BACK
    } cell_op_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t op;
        word_t    value;
    } cell_ctrl_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic  valid;
        word_t word;
    } cell_data_t;

endpackage

`default_nettype wire

FILE: rtl/bdeq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bdeq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [bdeq_pkg::ACTION_W-1:0]        action;
    logic signed [bdeq_pkg::WORD_W-1:0]   push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink (input valid, input action, input push_value, output ready);
endinterface

interface bdeq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bdeq_pkg::WORD_W-1:0]   out_value;
    logic [bdeq_pkg::STATUS_W-1:0]        status;
    logic                                 last;

    modport source (output valid, output out_value, output status, output last, input ready);
    modport sink (input valid, input out_value, input status, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdeq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bdeq_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bdeq_pkg::cell_ctrl_t    ctrl,
    input  wire bdeq_pkg::cell_data_t    left,
    input  wire bdeq_pkg::cell_data_t    right,
    output bdeq_pkg::cell_data_t         data
);

    logic                valid_reg;
    logic                valid_next;
    bdeq_pkg::word_t     word_reg;
    bdeq_pkg::word_t     word_next;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        case (ctrl.op)
            bdeq_pkg::CELL_PUSH_FRONT:
            begin
                valid_next = left.valid;
                word_next  = left.word;
            end
            bdeq_pkg::CELL_PUSH_BACK:
            begin
                // Only the first empty cell behind the occupied run takes the word.
                if (!valid_reg && left.valid)
                begin
                    valid_next = 1'b1;
                    word_next  = ctrl.value;
                end
            end
            bdeq_pkg::CELL_POP_FRONT:
            begin
                valid_next = right.valid;
                word_next  = right.word;
            end
            bdeq_pkg::CELL_POP_BACK:
            begin
                if (valid_reg && !right.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign data.valid = valid_reg;
    assign data.word  = word_reg;

endmodule

`default_nettype wire

FILE: rtl/bounded_double_ended_queue_core.sv
// A result is in the output register in the cycle after its item's transfer.
// Throughput: push and pop items transfer once per cycle while no drain runs and the
// output register is free; the output register drains while the next item comes in.
// Drain of N stored words gives N results, one cell shift each.
// Reset clears cell occupancy, the drain state and the output valid; words are not reset.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue_core #(
    parameter int unsigned DEPTH = bdeq_pkg::DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bdeq_in_if.sink      cmd,
    bdeq_out_if.source   rsp
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;

    bdeq_pkg::cell_ctrl_t            ctrl;
    bdeq_pkg::cell_data_t            cell_q [DEPTH];
    logic [DEPTH:0]                  valid_ext;
    bdeq_pkg::word_t                 back_word;

    logic                            rsp_valid_reg;
    bdeq_pkg::word_t                 rsp_value_reg;
    logic [bdeq_pkg::STATUS_W-1:0]   rsp_status_reg;
    logic                            rsp_last_reg;

    logic                            load;
    bdeq_pkg::word_t                 value_next;
    logic [bdeq_pkg::STATUS_W-1:0]   status_next;
    logic                            last_next;

    logic                            out_free;
    logic                            accept;
    logic                            empty;
    logic                            full;

    // Row of cells: cell 0 is the front, the push value enters from its left.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bdeq_pkg::cell_data_t left_d;
        bdeq_pkg::cell_data_t right_d;

        if (i == 0)
        begin : g_first
            assign left_d.valid = 1'b1;
            assign left_d.word  = cmd.push_value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d.valid = 1'b0;
            assign right_d.word  = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[i+1];
        end

        bdeq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_d),
            .right (right_d),
            .data  (cell_q[i])
        );

        assign valid_ext[i] = cell_q[i].valid;
    end

    assign valid_ext[DEPTH] = 1'b0;

    // The back word sits in the last occupied cell.
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (valid_ext[i] && !valid_ext[i+1])
            begin
                back_word = back_word | cell_q[i].word;
            end
        end
    end

    assign empty    = !valid_ext[0];
    assign full     = valid_ext[DEPTH-1];
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept   = cmd.valid && cmd.ready;

    always_comb
    begin
        ctrl.op     = bdeq_pkg::CELL_HOLD;
        ctrl.value  = cmd.push_value;
        load        = 1'b0;
        value_next  = '0;
        status_next = bdeq_pkg::ST_OK;
        last_next   = 1'b1;
        state_next  = state_reg;

        if (accept)
        begin
            case (cmd.action)
                bdeq_pkg::ACT_PUSH_FRONT:
                begin
                    load = 1'b1;
                    if (full)
                    begin
                        status_next = bdeq_pkg::ST_OVER;
                    end
                    else
                    begin
                        ctrl.op = bdeq_pkg::CELL_PUSH_FRONT;
                    end
                end
                bdeq_pkg::ACT_PUSH_BACK:
                begin
                    load = 1'b1;
                    if (full)
                    begin
                        status_next = bdeq_pkg::ST_OVER;
                    end
                    else
                    begin
                        ctrl.op = bdeq_pkg::CELL_PUSH_BACK;
                    end
                end
                bdeq_pkg::ACT_POP_FRONT:
                begin
                    load = 1'b1;
                    if (empty)
                    begin
                        status_next = bdeq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        ctrl.op    = bdeq_pkg::CELL_POP_FRONT;
                        value_next = cell_q[0].word;
                    end
                end
                bdeq_pkg::ACT_POP_BACK:
                begin
                    load = 1'b1;
                    if (empty)
                    begin
                        status_next = bdeq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        ctrl.op    = bdeq_pkg::CELL_POP_BACK;
                        value_next = back_word;
                    end
                end
                bdeq_pkg::ACT_DRAIN:
                begin
                    load = 1'b1;
                    if (empty)
                    begin
                        status_next = bdeq_pkg::ST_UNDER;
                    end
                    else
                    begin
                        ctrl.op    = bdeq_pkg::CELL_POP_FRONT;
                        value_next = cell_q[0].word;
                        last_next  = !valid_ext[1];
                        if (valid_ext[1])
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if ((state_reg == S_DRAIN) && out_free)
        begin
            load       = 1'b1;
            ctrl.op    = bdeq_pkg::CELL_POP_FRONT;
            value_next = cell_q[0].word;
            last_next  = !valid_ext[1];
            if (!valid_ext[1])
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_value_reg  <= value_next;
            rsp_status_reg <= status_next;
            rsp_last_reg   <= last_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_value = rsp_value_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.last      = rsp_last_reg;

endmodule

`default_nettype wire

FILE: rtl/bdeq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bdeq_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                cmd_valid,
    input wire logic                                cmd_ready,
    input wire logic [bdeq_pkg::ACTION_W-1:0]       cmd_action,
    input wire logic                                rsp_valid,
    input wire logic                                rsp_ready,
    input wire logic signed [bdeq_pkg::WORD_W-1:0]  rsp_out_value,
    input wire logic [bdeq_pkg::STATUS_W-1:0]       rsp_status,
    input wire logic                                rsp_last
);

    // A stalled result keeps its contents.
    `BDEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_value) && $stable(rsp_status) && $stable(rsp_last))

    // Error results carry no word and always end their item.
    `BDEQ_ASSERT_SAME(a_err_shape, rsp_valid && (rsp_status != bdeq_pkg::ST_OK), rsp_last && (rsp_out_value == '0))

    // A push always answers in the next cycle and never reports underflow.
    `BDEQ_ASSERT_NEXT(a_push_rsp, cmd_valid && cmd_ready && (cmd_action == bdeq_pkg::ACT_PUSH_FRONT || cmd_action == bdeq_pkg::ACT_PUSH_BACK), rsp_valid && (rsp_status != bdeq_pkg::ST_UNDER))

    // No new transfer is taken while a drain is still producing words.
    `BDEQ_ASSERT_SAME(a_drain_block, rsp_valid && !rsp_last, !cmd_ready)

endmodule

bind bounded_double_ended_queue_core bdeq_checker u_bdeq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_action    (cmd.action),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_out_value (rsp.out_value),
    .rsp_status    (rsp.status),
    .rsp_last      (rsp.last)
);

`default_nettype wire
